// ===== src/spi_master_register_block_top_defines.svh =====
// Assertion macros used by the checker file
`ifndef SPI_MASTER_REGISTER_BLOCK_TOP_DEFINES_SVH
`define SPI_MASTER_REGISTER_BLOCK_TOP_DEFINES_SVH

// implication checked outside reset
`define SPIMRB_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, also checked across reset
`define SPIMRB_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/spimrb_pkg.sv =====
`default_nettype none
package spimrb_pkg;

   localparam int RX_DEPTH_DEF = 8;
   localparam int CS_LINES_DEF = 4;

   // register offsets
   localparam logic [2:0] OFF_CTRL    = 3'd0;
   localparam logic [2:0] OFF_STATUS  = 3'd1;
   localparam logic [2:0] OFF_DATA    = 3'd2;
   localparam logic [2:0] OFF_EXT     = 3'd3;
   localparam logic [2:0] OFF_PARAM   = 3'd4;
   localparam logic [2:0] OFF_CHIPSEL = 3'd5;
   localparam logic [2:0] OFF_TIMING  = 3'd6;

   // status bit positions
   localparam int ST_DONE   = 7;
   localparam int ST_WFULL  = 3;
   localparam int ST_WEMPTY = 2;
   localparam int ST_RFULL  = 1;
   localparam int ST_REMPTY = 0;

   localparam logic [7:0] STATUS_RST = 8'h05;

   typedef struct packed {
      logic       push;
      logic       pop;
      logic [7:0] wdata;
   } fifo_ctrl_type;

   typedef struct packed {
      logic [7:0] rdata;   // entry at the read pointer
      logic       eq;      // pointers equal after this request
      logic       full;    // pointers one short of meeting after this request
   } fifo_stat_type;

endpackage
`default_nettype wire

// ===== src/spimrb_rx_fifo.sv =====
`default_nettype none
module spimrb_rx_fifo #(
   parameter int RX_DEPTH = spimrb_pkg::RX_DEPTH_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire spimrb_pkg::fifo_ctrl_type ctrl,
   output spimrb_pkg::fifo_stat_type      stat
);
   import spimrb_pkg::*;

   localparam int PTR_W = $clog2(RX_DEPTH);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RX_DEPTH - 1);

   logic [7:0]       mem [RX_DEPTH];
   logic [PTR_W-1:0] head_ff, head_in;
   logic [PTR_W-1:0] tail_ff, tail_in;
   logic [PTR_W-1:0] head_inc;
   logic [7:0]       rdata_ff;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      ptr_next = (p == PTR_LAST) ? '0 : p + PTR_W'(1);
   endfunction

   always_comb begin
      head_in  = ctrl.push ? ptr_next(head_ff) : head_ff;
      tail_in  = ctrl.pop  ? ptr_next(tail_ff) : tail_ff;
      head_inc = ptr_next(head_in);
      stat.rdata = rdata_ff;
      stat.eq    = (head_in == tail_in);
      stat.full  = (head_inc == tail_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
      end
   end

   // storage and look-ahead read of the next entry to pop
   always_ff @(posedge clock) begin
      if (ctrl.push) begin
         mem[head_ff] <= ctrl.wdata;
      end
      if (ctrl.push && head_ff == tail_in) begin
         rdata_ff <= ctrl.wdata;
      end else begin
         rdata_ff <= mem[tail_in];
      end
   end

endmodule
`default_nettype wire

// ===== src/spi_master_register_block_top.sv =====
// A request's response is valid the cycle after acceptance.
// Throughput: one request per cycle while the response is not stalled; the response register frees as it is taken.
// Reset (synchronous): registers, pointers, chip selects and interrupt clear,
// status reads 0x05. Receive FIFO storage is not cleared.
`default_nettype none
module spi_master_register_block_top #(
   parameter int RX_DEPTH = spimrb_pkg::RX_DEPTH_DEF,
   parameter int CS_LINES = spimrb_pkg::CS_LINES_DEF
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic       req_type,
   input  wire logic [2:0] req_reg_offset,
   input  wire logic [7:0] req_write_data,
   input  wire logic [7:0] req_slave_data,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_read_data,
   output logic            rsp_irq_out,
   output logic [3:0]      rsp_chip_selects,
   output logic            rsp_send_valid,
   output logic [7:0]      rsp_send_data
);
   import spimrb_pkg::*;

   logic          req_fire;
   fifo_ctrl_type fctl;
   fifo_stat_type fstat;
   logic          rebuild;

   logic [7:0] ctrl_ff, ctrl_in;
   logic [7:0] status_ff, status_in;
   logic [7:0] ext_ff, ext_in;
   logic [7:0] param_ff, param_in;
   logic [7:0] chipsel_ff, chipsel_in;
   logic [7:0] timing_ff, timing_in;
   logic [3:0] cs_ff, cs_in;
   logic       irq_ff, irq_in;
   logic [7:0] status_tmp;
   logic [7:0] rdata;

   logic       rsp_valid_ff;
   logic [7:0] rsp_rdata_ff;
   logic       rsp_irq_ff;
   logic [3:0] rsp_cs_ff;
   logic       rsp_sent_ff;
   logic [7:0] rsp_sbyte_ff;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign req_fire  = req_valid & ~req_stall;

   // FIFO request decode
   always_comb begin
      fctl    = '0;
      rebuild = 1'b0;
      fctl.wdata = req_slave_data;
      if (req_fire && req_reg_offset == OFF_DATA) begin
         rebuild = 1'b1;
         if (req_type) begin
            fctl.push = ~status_ff[ST_RFULL];
         end else begin
            fctl.pop = ~status_ff[ST_REMPTY];
         end
      end
   end

   spimrb_rx_fifo #(
      .RX_DEPTH(RX_DEPTH)
   ) u_rx_fifo (
      .clock(clock),
      .reset(reset),
      .ctrl (fctl),
      .stat (fstat)
   );

   always_comb begin
      ctrl_in    = ctrl_ff;
      status_tmp = status_ff;
      ext_in     = ext_ff;
      param_in   = param_ff;
      chipsel_in = chipsel_ff;
      timing_in  = timing_ff;
      cs_in      = cs_ff;
      irq_in     = irq_ff;
      rdata      = 8'h00;
      if (req_fire) begin
         if (!req_type) begin
            case (req_reg_offset)
               OFF_CTRL:    rdata = ctrl_ff;
               OFF_STATUS:  rdata = status_ff;
               OFF_DATA:    rdata = fctl.pop ? fstat.rdata : 8'h00;
               OFF_EXT:     rdata = ext_ff;
               OFF_PARAM:   rdata = param_ff;
               OFF_CHIPSEL: rdata = chipsel_ff;
               OFF_TIMING:  rdata = timing_ff;
               default:     rdata = 8'h00;
            endcase
         end else begin
            case (req_reg_offset)
               OFF_CTRL:   ctrl_in = req_write_data;
               OFF_STATUS: status_tmp = status_ff & ~req_write_data;
               OFF_DATA:   status_tmp[ST_DONE] = fctl.push;
               OFF_EXT:    ext_in = req_write_data;
               OFF_PARAM:  param_in = req_write_data;
               OFF_CHIPSEL: begin
                  chipsel_in = req_write_data;
                  for (int i = 0; i < 4; i++) begin
                     if (i < CS_LINES && req_write_data[i]) begin
                        cs_in[i] = req_write_data[i+4];
                     end
                  end
               end
               OFF_TIMING: timing_in = req_write_data;
               default:    ;
            endcase
         end
      end
      status_in = status_tmp;
      if (rebuild) begin
         status_in[ST_WFULL]  = 1'b0;
         status_in[ST_WEMPTY] = 1'b1;
         status_in[ST_RFULL]  = fstat.full;
         status_in[ST_REMPTY] = fstat.eq;
         irq_in = fstat.full;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff    <= '0;
         status_ff  <= STATUS_RST;
         ext_ff     <= '0;
         param_ff   <= '0;
         chipsel_ff <= '0;
         timing_ff  <= '0;
         cs_ff      <= '0;
         irq_ff     <= 1'b0;
      end else begin
         ctrl_ff    <= ctrl_in;
         status_ff  <= status_in;
         ext_ff     <= ext_in;
         param_ff   <= param_in;
         chipsel_ff <= chipsel_in;
         timing_ff  <= timing_in;
         cs_ff      <= cs_in;
         irq_ff     <= irq_in;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_rdata_ff <= rdata;
         rsp_irq_ff   <= irq_in;
         rsp_cs_ff    <= cs_in;
         rsp_sent_ff  <= req_type && req_reg_offset == OFF_DATA;
         rsp_sbyte_ff <= (req_type && req_reg_offset == OFF_DATA) ? req_write_data : 8'h00;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_read_data    = rsp_rdata_ff;
   assign rsp_irq_out      = rsp_irq_ff;
   assign rsp_chip_selects = rsp_cs_ff;
   assign rsp_send_valid   = rsp_sent_ff;
   assign rsp_send_data    = rsp_sbyte_ff;

endmodule
`default_nettype wire

// ===== src/spimrb_checker.sv =====
`default_nettype none
`include "spi_master_register_block_top_defines.svh"
module spimrb_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_stall,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic [7:0] rsp_read_data,
   input wire logic       rsp_send_valid,
   input wire logic [7:0] rsp_send_data
);

   // a sending request is a write, so it returns no read data
   `SPIMRB_ASSERT_IMP(a_send_no_rdata, rsp_valid && rsp_send_valid, rsp_read_data == 8'h00, "send with read data")
   // nothing sent means a zero send byte
   `SPIMRB_ASSERT_IMP(a_nosend_zero, rsp_valid && !rsp_send_valid, rsp_send_data == 8'h00, "send byte without send")
   // every accepted request yields a response next cycle
   `SPIMRB_ASSERT_NXT(a_req_rsp, !reset && req_valid && !req_stall, rsp_valid, "request without response")
   // no response straight out of reset
   `SPIMRB_ASSERT_NXT(a_rst_idle, reset, !rsp_valid, "response after reset")

endmodule

bind spi_master_register_block_top spimrb_checker u_spimrb_checker (.*);
`default_nettype wire
